// ===== hw/rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the sha-256 message hasher
// round constants, initial hash values and channel payload types
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_end;
    } t_out_item;

    // control between sequencer and round unit
    typedef struct packed {
        logic       init;   // load working vars from chaining value
        logic       round;  // run one round
        logic       fold;   // add working vars into chaining value
        logic       restart;
        logic [5:0] rnd;
    } t_rnd_ctl;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if: valid-ready channels
// carry one request or result payload each
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic valid;
    logic ready;
    sha_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sha_out_if;
    logic valid;
    logic ready;
    sha_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sha_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_round: shared round unit
// holds working vars, a 16-word schedule window and the chaining value
// ----------------------------------------------------------------------------
module sha_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha_pkg::t_rnd_ctl i_ctl,
    input  logic             i_load,      // shift a block word into the window
    input  logic [31:0]      i_word,
    input  logic [2:0]       i_sel,
    output logic [31:0]      o_hash
);
    import sha_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [31:0] s0, s1, wn, t1, t2;

    assign o_hash = r_h[i_sel];

    always_comb begin
        s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K[i_ctl.rnd] + r_w[0];
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // window slot 0 holds w[t]; each round shifts in w[t+16]
    always_ff @(posedge i_clk) begin
        if (i_load || i_ctl.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_load ? i_word : wn;
        end
        if (i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.round) begin
            for (int i = 1; i < 8; i++) r_v[i] <= r_v[i-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            for (int i = 0; i < 8; i++) r_h[i] <= H0[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end
endmodule

// ===== hw/rtl/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// a word that fills a block is followed by init, 64 rounds and fold
// other words are only shifted into the window; a last word adds padding words at one a cycle
// and then eight digest words, one per cycle when the sink is ready
// new words are taken only in idle, never while the single shared round unit compresses a block
// synchronous active-low reset restores the initial hash and clears the count
// ----------------------------------------------------------------------------
// sha256_message_hasher: sha-256 over a stream of 32-bit words
// padding sequencer in front of a one-round-per-cycle compression unit
// ----------------------------------------------------------------------------
module sha256_message_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    i_req,
    sha_out_if.source o_res
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_INIT = 3'd2,
                           S_RND = 3'd3, S_FOLD = 3'd4, S_OUT = 3'd5;

    logic [2:0]  r_st, n_st;
    logic [3:0]  r_slot;
    logic [63:0] r_cnt;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oi;
    logic        r_fin, r_pend80;   // finishing; 0x80 word still owed
    logic        r_lenlo;           // next pad word is length low
    logic        ld;
    logic [31:0] wd, keep, pw;
    logic [2:0]  nb;
    t_rnd_ctl    ctl;

    assign i_req.ready = (r_st == S_IDLE);
    assign o_res.valid = (r_st == S_OUT);
    assign o_res.data.word_index = r_oi;
    assign o_res.data.digest_end = (r_oi == 3'd7);

    always_comb begin
        nb = (i_req.data.valid_bytes > 3'd4 || !i_req.data.last_word) ? 3'd4
             : i_req.data.valid_bytes;
        keep = (nb == 3'd0) ? 32'h0 : ~(32'hffffffff >> {nb, 3'b000});
        // pad word during S_PAD
        if (r_pend80) pw = 32'h80000000;
        else if (r_lenlo) pw = r_cnt[31:0];
        else if (r_slot == 4'd14) pw = r_cnt[63:32];
        else pw = 32'h0;
        ld = 1'b0;
        wd = pw;
        if (r_st == S_IDLE && i_req.valid) begin
            ld = 1'b1;
            wd = (nb == 3'd4) ? i_req.data.data_word
                 : ((i_req.data.data_word & keep) | (32'h80000000 >> {nb, 3'b000}));
        end else if (r_st == S_PAD) begin
            ld = 1'b1;
        end
        ctl.init = (r_st == S_INIT);
        ctl.round = (r_st == S_RND);
        ctl.fold = (r_st == S_FOLD);
        ctl.rnd = r_rnd;
        ctl.restart = (r_st == S_OUT) && o_res.ready && (r_oi == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_slot <= '0; r_cnt <= '0; r_rnd <= '0; r_oi <= '0;
            r_fin <= 1'b0; r_pend80 <= 1'b0; r_lenlo <= 1'b0;
        end else begin
            if (ld) r_slot <= r_slot + 4'd1;
            case (r_st)
                S_IDLE: if (i_req.valid) begin
                    r_cnt <= r_cnt + {58'd0, nb, 3'b000};
                    r_fin <= i_req.data.last_word;
                    r_pend80 <= i_req.data.last_word && (nb == 3'd4);
                    if (r_slot == 4'd15) r_st <= S_INIT;
                    else if (i_req.data.last_word) r_st <= S_PAD;
                end
                S_PAD: begin
                    if (r_pend80) r_pend80 <= 1'b0;
                    else if (r_slot == 4'd14) r_lenlo <= 1'b1;
                    if (r_slot == 4'd15) r_st <= S_INIT;
                end
                S_INIT: begin r_rnd <= '0; r_st <= S_RND; end
                S_RND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_st <= S_FOLD;
                end
                S_FOLD: begin
                    if (r_lenlo) begin r_lenlo <= 1'b0; r_oi <= '0; r_st <= S_OUT; end
                    else if (r_fin) r_st <= S_PAD;
                    else r_st <= S_IDLE;
                end
                S_OUT: if (o_res.ready) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        r_st <= S_IDLE; r_cnt <= '0; r_slot <= '0; r_fin <= 1'b0;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    sha_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_load(ld),
        .i_word(wd), .i_sel(r_oi), .o_hash(o_res.data.digest_word)
    );
endmodule
